@@ hw/rtl/mds_pkg.sv @@
`default_nettype none

package mds_pkg;

    localparam int unsigned CFG_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned PORTION_W  = 8;
    localparam int unsigned FEED_W     = 16;

    localparam logic [CFG_W-1:0] RESET_REVERSE_MS = 16'd500;
    localparam logic [CFG_W-1:0] RESET_PAUSE_MS   = 16'd500;
    localparam logic [CFG_W-1:0] RESET_REST_MS    = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REST    = 2'd2;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_RESET = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        PH_BEGIN   = 3'd0,
        PH_REVERSE = 3'd1,
        PH_PAUSE   = 3'd2,
        PH_FORWARD = 3'd3,
        PH_REST    = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        DRIVE_OFF = 2'd0,
        DRIVE_FWD = 2'd1,
        DRIVE_BWD = 2'd2
    } t_drive;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_BEGAN = 2'd1;
    localparam logic [1:0] EV_ENDED = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] reverse_ms;
        logic [CFG_W-1:0] pause_ms;
        logic [CFG_W-1:0] rest_ms;
    } t_cfg;

    typedef struct packed {
        logic                 pin_a;
        logic                 pin_b;
        logic                 running;
        logic [1:0]           feed_event;
        logic [PORTION_W-1:0] portions_left;
        logic [2:0]           phase;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/mds_cfg.sv @@
`default_nettype none

module mds_cfg
    import mds_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reverse_ms <= RESET_REVERSE_MS;
            r_cfg.pause_ms   <= RESET_PAUSE_MS;
            r_cfg.rest_ms    <= RESET_REST_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REVERSE: r_cfg.reverse_ms <= i_cfg_wdata;
                CFG_PAUSE:   r_cfg.pause_ms   <= i_cfg_wdata;
                CFG_REST:    r_cfg.rest_ms    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/mds_core.sv @@
`default_nettype none

module mds_core
    import mds_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_exec,
    input  var  t_req                 i_req,
    input  wire logic [PORTION_W-1:0] i_portion_count,
    input  wire logic [FEED_W-1:0]    i_feed_ticks,
    input  var  t_cfg                 i_cfg,
    output t_result                   o_result
);

    localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    t_phase                r_phase,    n_phase;
    t_drive                r_drive,    n_drive;
    logic [PORTION_W-1:0]  r_portions, n_portions;
    logic [TIMER_BITS-1:0] r_elapsed,  n_elapsed;
    logic [FEED_W-1:0]     r_feed_len, n_feed_len;
    logic                  r_running,  n_running;
    logic [1:0]            event_code;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]      elapsed_cmp;
    logic                  reverse_done;
    logic                  pause_done;
    logic                  forward_done;
    logic                  rest_done;

    // saturating tick counter, phases compare against the advanced value
    assign elapsed_inc  = (r_elapsed == TIMER_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign elapsed_cmp  = CMP_W'(elapsed_inc);
    assign reverse_done = elapsed_cmp >= CMP_W'(i_cfg.reverse_ms);
    assign pause_done   = elapsed_cmp >= CMP_W'(i_cfg.pause_ms);
    assign forward_done = elapsed_cmp >= CMP_W'(r_feed_len);
    assign rest_done    = elapsed_cmp >= CMP_W'(i_cfg.rest_ms);

    always_comb begin
        n_phase    = r_phase;
        n_drive    = r_drive;
        n_portions = r_portions;
        n_elapsed  = r_elapsed;
        n_feed_len = r_feed_len;
        n_running  = r_running;
        event_code = EV_NONE;
        unique case (i_req)
            REQ_TICK: begin
                n_elapsed = elapsed_inc;
                if (r_portions == '0) begin
                    if (r_running) begin
                        n_drive    = DRIVE_OFF;
                        n_running  = 1'b0;
                        event_code = EV_ENDED;
                    end
                end else begin
                    unique case (r_phase)
                        PH_BEGIN: begin
                            n_elapsed = '0;
                            n_drive   = DRIVE_BWD;
                            n_phase   = PH_REVERSE;
                        end
                        PH_REVERSE: begin
                            if (reverse_done) begin
                                n_elapsed = '0;
                                n_drive   = DRIVE_OFF;
                                n_phase   = PH_PAUSE;
                            end
                        end
                        PH_PAUSE: begin
                            if (pause_done) begin
                                n_elapsed = '0;
                                n_drive   = DRIVE_FWD;
                                n_phase   = PH_FORWARD;
                            end
                        end
                        PH_FORWARD: begin
                            if (forward_done) begin
                                n_elapsed = '0;
                                n_drive   = DRIVE_OFF;
                                n_phase   = PH_REST;
                            end
                        end
                        PH_REST: begin
                            if (rest_done) begin
                                n_elapsed  = '0;
                                n_portions = r_portions - 1'b1;
                                n_phase    = PH_BEGIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            REQ_START: begin
                n_elapsed  = '0;
                n_phase    = PH_BEGIN;
                n_portions = i_portion_count;
                n_feed_len = i_feed_ticks;
                n_running  = 1'b1;
                event_code = EV_BEGAN;
            end
            REQ_STOP: begin
                n_drive    = DRIVE_OFF;
                n_running  = 1'b0;
                event_code = EV_ENDED;
            end
            REQ_RESET: begin
                n_portions = '0;
                n_drive    = DRIVE_OFF;
                n_running  = 1'b0;
                event_code = EV_ENDED;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_BEGIN;
            r_drive    <= DRIVE_OFF;
            r_portions <= '0;
            r_elapsed  <= '0;
            r_feed_len <= '0;
            r_running  <= 1'b0;
        end else if (i_exec) begin
            r_phase    <= n_phase;
            r_drive    <= n_drive;
            r_portions <= n_portions;
            r_elapsed  <= n_elapsed;
            r_feed_len <= n_feed_len;
            r_running  <= n_running;
        end
    end

    assign o_result.pin_a         = (n_drive == DRIVE_FWD);
    assign o_result.pin_b         = (n_drive == DRIVE_BWD);
    assign o_result.running       = n_running;
    assign o_result.feed_event    = event_code;
    assign o_result.portions_left = n_portions;
    assign o_result.phase         = n_phase;

endmodule

`default_nettype wire

@@ hw/rtl/motor_dose_sequencer.sv @@
// motor dose sequencer: runs an h-bridge through reverse, pause, forward and
// rest once per portion, counting portions down to zero.
// input channel (i_in_valid / o_in_ready): one word per request, a one
// millisecond tick, start (loads portion count and feed ticks), stop or reset.
// output channel (o_out_valid / i_out_ready): exactly one result word per
// request: bridge pin levels, running flag, begin/end event, portions left
// and current phase.
// config port: i_cfg_we with i_cfg_idx 0 reverse, 1 pause, 2 rest time in
// ticks; the user writes it only while no request is in flight, which the
// block does not enforce; index 3 is ignored. a word accepted into the input
// register passes through the step logic into the result register.
// throughput: one word per clock while the receiver takes results; the step
// logic is an increment, a decrement, four threshold compares and selection.
// when the receiver stalls the result register holds, the input register
// fills, and o_in_ready drops only while both are full.
// reset (synchronous, active low) empties both registers, sets the core's
// drive off, clears session state and loads 500/500/1000 tick phase times.
`default_nettype none

module motor_dose_sequencer
    import mds_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [PORTION_W-1:0] i_portion_count,
    input  wire logic [FEED_W-1:0]    i_feed_ticks,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_pin_a,
    output logic                      o_pin_b,
    output logic                      o_running,
    output logic [1:0]                o_feed_event,
    output logic [PORTION_W-1:0]      o_portions_left,
    output logic [2:0]                o_phase,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    logic                 r_in_valid;
    t_req                 r_req;
    logic [PORTION_W-1:0] r_portion_count;
    logic [FEED_W-1:0]    r_feed_ticks;
    logic                 r_out_valid;
    t_result              r_result;
    t_result              step_result;
    t_cfg                 cfg;
    logic                 exec;
    logic                 in_fire;

    assign exec       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (exec) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req           <= t_req'(i_req_type);
            r_portion_count <= i_portion_count;
            r_feed_ticks    <= i_feed_ticks;
        end
    end

    mds_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mds_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_exec          (exec),
        .i_req           (r_req),
        .i_portion_count (r_portion_count),
        .i_feed_ticks    (r_feed_ticks),
        .i_cfg           (cfg),
        .o_result        (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pin_a         = r_result.pin_a;
    assign o_pin_b         = r_result.pin_b;
    assign o_running       = r_result.running;
    assign o_feed_event    = r_result.feed_event;
    assign o_portions_left = r_result.portions_left;
    assign o_phase         = r_result.phase;

`ifndef SYNTHESIS
    a_pins_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_pin_a && o_pin_b))
        else $error("both bridge inputs driven");

    a_began_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_feed_event == EV_BEGAN) |-> o_running)
        else $error("begin event without running session");

    a_ended_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_feed_event == EV_ENDED) |-> (!o_running && !o_pin_a && !o_pin_b))
        else $error("end event with motor still held");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> (!o_in_ready && !exec))
        else $error("word taken while both stages are full and stalled");
`endif

endmodule

`default_nettype wire
